// ----- hdl/rlw_pkg.sv -----
// ----------------------------------------------------------------------------
// rlw_pkg: shared types and constants for the row linear interpolation warp
// Item structs, register indexes, controller states and command bundle.
// ----------------------------------------------------------------------------
package rlw_pkg;

  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned FRAC_W      = 4;
  localparam int unsigned RW_W        = 11;
  localparam int unsigned COL_W       = 10;
  localparam int unsigned SAMPLE_W    = 8;
  localparam int unsigned OFFSET_W    = 16;
  localparam int unsigned CFG_DATA_W  = 11;

  localparam logic [CFG_IDX_W-1:0] REG_FRAC_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 2'd1;

  localparam logic [FRAC_W-1:0] FRAC_BITS_RESET = 4'd8;
  localparam logic [RW_W-1:0]   ROW_WIDTH_RESET = 11'd1024;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_COMPUTE = 1'b1;

  typedef struct packed {
    logic                       kind;
    logic [COL_W-1:0]           column;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [OFFSET_W-1:0] offset;
  } rlw_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_value;
    logic [COL_W-1:0]           out_column;
  } rlw_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADDR,
    ST_MUL,
    ST_SUM
  } rlw_state_t;

  typedef struct packed {
    logic capture;
    logic store_wr;
    logic tap_rd;
    logic mul_en;
    logic out_en;
  } rlw_cmd_t;

endpackage

// ----- hdl/row_linear_interp_warp.sv -----
// ----------------------------------------------------------------------------
// row_linear_interp_warp: horizontal row warp with linear interpolation
// Warps one row by a signed fixed-point offset per output pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on cmd when start is high and busy is low. A load item
//   (kind 0) writes sample into the row store at column and finishes in the
//   accepting cycle; busy stays low, so loads can stream one per cycle.
//   A compute item (kind 1) raises busy while the controller steps through
//   tap address and store read, weight multiplies, and sum and shift; the
//   result is registered at the sum phase and appears on result with done
//   high for exactly one cycle once the controller is idle again, so the next
//   item can be taken alongside it. No new item is taken while busy is high.
//   Registers frac_bits (index 0) and row_width (index 1) are written over
//   cfg_valid/cfg_ready; cfg_ready is always high. Write them while idle.
//   Synchronous reset returns the controller to idle, drops done and sets
//   frac_bits to 8, row_width to 1024. The row store is not cleared; load
//   every column before computing. done cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module row_linear_interp_warp #(
  parameter int unsigned MAX_ROW_WIDTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  rlw_pkg::rlw_in_t                cmd,
  output logic                            done,
  output rlw_pkg::rlw_out_t               result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rlw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rlw_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rlw_pkg::*;

  rlw_cmd_t ctrl_cmd;

  assign cfg_ready = 1'b1;

  rlw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (cmd.kind),
    .busy  (busy),
    .cmd   (ctrl_cmd)
  );

  rlw_dp #(
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (ctrl_cmd),
    .item      (cmd),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result),
    .done      (done)
  );

endmodule

// ----- hdl/rlw_ctrl.sv -----
// ----------------------------------------------------------------------------
// rlw_ctrl: sequencing controller
// Accepts items while idle and steps a compute item through address,
// multiply and sum phases of the datapath.
// ----------------------------------------------------------------------------
module rlw_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            kind,
  output logic            busy,
  output rlw_pkg::rlw_cmd_t cmd
);
  import rlw_pkg::*;

  rlw_state_t state;
  rlw_state_t state_next;
  logic       accept;

  assign accept = start && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (kind == KIND_COMPUTE)) begin
          state_next = ST_ADDR;
        end
      end
      ST_ADDR: state_next = ST_MUL;
      ST_MUL:  state_next = ST_SUM;
      ST_SUM:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy         = 1'b1;
    cmd.capture  = 1'b0;
    cmd.store_wr = 1'b0;
    cmd.tap_rd   = 1'b0;
    cmd.mul_en   = 1'b0;
    cmd.out_en   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy         = 1'b0;
        cmd.capture  = accept;
        cmd.store_wr = accept && (kind == KIND_LOAD);
      end
      ST_ADDR: cmd.tap_rd = 1'b1;
      ST_MUL:  cmd.mul_en = 1'b1;
      ST_SUM:  cmd.out_en = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

// ----- hdl/rlw_dp.sv -----
// ----------------------------------------------------------------------------
// rlw_dp: interpolation datapath
// Row store, config registers, tap addressing, two weight multiplies and
// the final shift and truncate.
// ----------------------------------------------------------------------------
module rlw_dp #(
  parameter int unsigned MAX_ROW_WIDTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  rlw_pkg::rlw_cmd_t                  cmd,
  input  rlw_pkg::rlw_in_t                   item,
  input  logic                               cfg_we,
  input  logic [rlw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rlw_pkg::CFG_DATA_W-1:0]     cfg_data,
  output rlw_pkg::rlw_out_t                  result,
  output logic                               done
);
  import rlw_pkg::*;

  localparam int unsigned AW    = (MAX_ROW_WIDTH > 2) ? $clog2(MAX_ROW_WIDTH) : 1;
  localparam int unsigned POS_W = 18;
  localparam int unsigned PROD_W = SAMPLE_W + OFFSET_W + 1;
  localparam int unsigned ACC_W  = PROD_W + 1;
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_ROW_WIDTH);

  logic signed [SAMPLE_W-1:0] row_store [MAX_ROW_WIDTH];

  logic [FRAC_W-1:0] frac_bits;
  logic [RW_W-1:0]   row_width;

  // captured item
  logic [COL_W-1:0]           col_q;
  logic signed [OFFSET_W-1:0] off_q;

  // address phase
  logic signed [OFFSET_W-1:0] ip;
  logic [OFFSET_W:0]          unit;
  logic [OFFSET_W-1:0]        lw;
  logic [OFFSET_W-1:0]        rw;
  logic signed [POS_W-1:0]    rpos;
  logic signed [POS_W-1:0]    lpos;
  logic [POS_W-1:0]           lim;
  logic                       l_ok;
  logic                       r_ok;
  logic [POS_W-1:0]           load_pos;

  logic [OFFSET_W-1:0]        lw_q;
  logic [OFFSET_W-1:0]        rw_q;
  logic                       l_ok_q;
  logic                       r_ok_q;
  logic signed [SAMPLE_W-1:0] ltap_q;
  logic signed [SAMPLE_W-1:0] rtap_q;

  // multiply and sum phases
  logic signed [SAMPLE_W-1:0] lv;
  logic signed [SAMPLE_W-1:0] rv;
  logic signed [PROD_W-1:0]   lprod_q;
  logic signed [PROD_W-1:0]   rprod_q;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    acc_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      frac_bits <= FRAC_BITS_RESET;
      row_width <= ROW_WIDTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAC_BITS: frac_bits <= cfg_data[FRAC_W-1:0];
        REG_ROW_WIDTH: row_width <= cfg_data[RW_W-1:0];
        default: ;
      endcase
    end
  end

  assign load_pos = POS_W'(item.column);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      col_q <= item.column;
      off_q <= item.offset;
    end
  end

  // integer part and weights; the fraction is the low frac_bits of the offset
  always_comb begin
    ip   = off_q >>> frac_bits;
    unit = (OFFSET_W+1)'(1) << frac_bits;
    lw   = off_q & OFFSET_W'(unit - (OFFSET_W+1)'(1));
    rw   = OFFSET_W'(unit - (OFFSET_W+1)'(lw));
    rpos = $signed(POS_W'(col_q)) - POS_W'(ip);
    lpos = rpos - POS_W'(1);
    lim  = (POS_W'(row_width) > MAX_POS) ? MAX_POS : POS_W'(row_width);
    l_ok = !lpos[POS_W-1] && ($unsigned(lpos) < lim);
    r_ok = !rpos[POS_W-1] && ($unsigned(rpos) < lim);
  end

  always_ff @(posedge clk) begin
    if (cmd.store_wr && (load_pos < MAX_POS)) begin
      row_store[load_pos[AW-1:0]] <= item.sample;
    end
    if (cmd.tap_rd) begin
      ltap_q <= row_store[lpos[AW-1:0]];
      rtap_q <= row_store[rpos[AW-1:0]];
      lw_q   <= lw;
      rw_q   <= rw;
      l_ok_q <= l_ok;
      r_ok_q <= r_ok;
    end
  end

  assign lv = l_ok_q ? ltap_q : '0;
  assign rv = r_ok_q ? rtap_q : '0;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      lprod_q <= PROD_W'(lv) * $signed({1'b0, lw_q});
      rprod_q <= PROD_W'(rv) * $signed({1'b0, rw_q});
    end
  end

  assign acc    = ACC_W'(lprod_q) + ACC_W'(rprod_q);
  assign acc_sh = acc >>> frac_bits;

  always_ff @(posedge clk) begin
    if (cmd.out_en) begin
      result.out_value  <= acc_sh[SAMPLE_W-1:0];
      result.out_column <= col_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.out_en;
    end
  end

endmodule

// ----- hdl/rlw_chk.sv -----
// ----------------------------------------------------------------------------
// rlw_chk: port-level checks for row_linear_interp_warp
// Compute result timing, load behaviour and the done strobe, bound to the top.
// ----------------------------------------------------------------------------
module rlw_chk (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input rlw_pkg::rlw_in_t  cmd,
  input logic              done
);
  import rlw_pkg::*;

  logic take_compute;
  logic take_load;

  assign take_compute = start && !busy && (cmd.kind == KIND_COMPUTE);
  assign take_load    = start && !busy && (cmd.kind == KIND_LOAD);

  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    take_compute |=> busy)
    else $error("compute item did not raise busy");

  a_compute_result: assert property (@(posedge clk) disable iff (rst)
    take_compute |-> ##4 done)
    else $error("compute item result missing four cycles after accept");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    take_load |=> (!busy && !done))
    else $error("load item produced a result or stalled the block");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

endmodule

bind row_linear_interp_warp rlw_chk u_rlw_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .cmd   (cmd),
  .done  (done)
);

// ----- verif/row_linear_interp_warp_tb.sv -----
// ----------------------------------------------------------------------------
// row_linear_interp_warp_tb: self-checking bench for the row warp
// Fills the row store, runs directed edge cases, then random phases over
// several frac_bits/row_width settings with random gaps between items.
// Every compute item is predicted locally and compared per field on done.
// ----------------------------------------------------------------------------
module row_linear_interp_warp_tb;
  import rlw_pkg::*;

  localparam int STORE_DEPTH = 1024;
  localparam int QUIET_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 8;

  // Local copy of the row store and registers, plus pixels still in flight.
  class warp_pixel_tracker;
    logic signed [SAMPLE_W-1:0] row_mem [STORE_DEPTH];
    logic [FRAC_W-1:0] frac_sh;
    logic [RW_W-1:0] width_reg;
    rlw_out_t pending_pixels[$];
    int errors;

    function new();
      frac_sh = FRAC_BITS_RESET;
      width_reg = ROW_WIDTH_RESET;
      errors = 0;
      foreach (row_mem[i]) row_mem[i] = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FRAC_BITS: frac_sh = data[FRAC_W-1:0];
        REG_ROW_WIDTH: width_reg = data[RW_W-1:0];
        default: ;
      endcase
    endfunction

    // zero padding outside the active row
    function int tap(int c);
      int lim;
      lim = int'(width_reg);
      if (lim > STORE_DEPTH) lim = STORE_DEPTH;
      if (c < 0 || c >= lim) return 0;
      return int'(row_mem[c]);
    endfunction

    function rlw_out_t interp_pixel(rlw_in_t it);
      int off, ip, lw, rw, acc, res, c;
      rlw_out_t o;
      off = int'(it.offset);
      c = int'(it.column);
      ip = off >>> frac_sh;
      lw = off - (ip <<< frac_sh);
      rw = (1 << frac_sh) - lw;
      acc = tap(c - ip - 1) * lw + tap(c - ip) * rw;
      res = acc >>> frac_sh;
      o.out_value = res[SAMPLE_W-1:0];
      o.out_column = it.column;
      return o;
    endfunction

    function void take_item(rlw_in_t it);
      if (it.kind == KIND_LOAD) row_mem[it.column] = it.sample;
      else pending_pixels.push_back(interp_pixel(it));
    endfunction

    function void match_pixel(rlw_out_t got);
      rlw_out_t want;
      if (pending_pixels.size() == 0) begin
        $error("result with no pending pixel: out_value %0d out_column %0d",
               $signed(got.out_value), got.out_column);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      if (got.out_value !== want.out_value) begin
        $error("out_value mismatch: expected %0d, got %0d",
               $signed(want.out_value), $signed(got.out_value));
        errors++;
      end
      if (got.out_column !== want.out_column) begin
        $error("out_column mismatch: expected %0d, got %0d",
               want.out_column, got.out_column);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  rlw_in_t cmd = '0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic busy;
  logic done;
  rlw_out_t result;
  logic cfg_ready;

  warp_pixel_tracker sb = new();
  bit steady_feed = 1'b0;
  int quiet = 0;

  row_linear_interp_warp DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Monitor and watchdog. Results are matched before the new item is noted,
  // since a result leaves on the same edge the next item can enter.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.match_pixel(result);
      if (start && !busy) sb.take_item(cmd);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (done || (start && !busy) || (cfg_valid && cfg_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic issue_item(rlw_in_t it);
    int gap;
    gap = steady_feed ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg_port(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic rlw_in_t mk_load(int col, int smp);
    rlw_in_t it;
    it.kind = KIND_LOAD;
    it.column = col[COL_W-1:0];
    it.sample = smp[SAMPLE_W-1:0];
    it.offset = OFFSET_W'($urandom);
    return it;
  endfunction

  function automatic rlw_in_t mk_comp(int col, logic [OFFSET_W-1:0] off);
    rlw_in_t it;
    it.kind = KIND_COMPUTE;
    it.column = col[COL_W-1:0];
    it.sample = SAMPLE_W'($urandom);
    it.offset = off;
    return it;
  endfunction

  initial begin
    int fb_list[6] = '{0, 15, 14, 4, 1, 12};
    int rw_list[6] = '{1024, 1024, 37, 1, 2047, 0};
    int fb, rw, lim, r, col, ip;
    logic [OFFSET_W-1:0] off;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every store entry gets written before any compute
    for (int c = 0; c < STORE_DEPTH; c++) issue_item(mk_load(c, $urandom));

    // directed: sample extremes and offset extremes at default settings
    issue_item(mk_load(5, -128));
    issue_item(mk_load(6, 127));
    issue_item(mk_comp(6, 16'h0080));
    issue_item(mk_comp(0, 16'h0000));
    issue_item(mk_comp(1023, 16'h0000));
    issue_item(mk_comp(512, 16'h7FFF));
    issue_item(mk_comp(512, 16'h8000));
    issue_item(mk_comp(0, 16'hFFFF));
    issue_item(mk_comp(1023, 16'hFF00));
    issue_item(mk_comp(0, 16'h0100));
    write_reg_port(REG_FRAC_BITS, 11'd0);
    issue_item(mk_comp(10, 16'h0003));
    issue_item(mk_comp(10, 16'hFFFB));
    // fifteen fraction bits: weights reach 2^15
    write_reg_port(REG_FRAC_BITS, 11'd15);
    issue_item(mk_comp(300, 16'h7FFF));
    issue_item(mk_comp(300, 16'h8000));
    write_reg_port(REG_FRAC_BITS, 11'd14);
    issue_item(mk_comp(2, 16'h4001));
    // empty row reads all zero
    write_reg_port(REG_ROW_WIDTH, 11'd0);
    issue_item(mk_comp(0, 16'h0000));
    // width above the store clamps to the store
    write_reg_port(REG_ROW_WIDTH, 11'd2047);
    issue_item(mk_comp(1023, 16'hFFFF));
    // narrow row: load beyond width still lands, compute beyond width pads
    write_reg_port(REG_FRAC_BITS, 11'd8);
    write_reg_port(REG_ROW_WIDTH, 11'd16);
    issue_item(mk_load(20, 99));
    issue_item(mk_comp(100, 16'h0000));
    issue_item(mk_comp(15, 16'hFF80));
    // unused register indexes must not disturb anything
    write_reg_port(2'd2, 11'h7FF);
    write_reg_port(2'd3, 11'h7FF);
    issue_item(mk_comp(8, 16'h0040));
    write_reg_port(REG_ROW_WIDTH, 11'd1024);
    issue_item(mk_comp(21, 16'h0100));
    write_reg_port(REG_ROW_WIDTH, 11'd1);
    issue_item(mk_comp(0, 16'h0080));
    issue_item(mk_comp(1, 16'h0180));

    // random phases
    for (int p = 0; p < 10; p++) begin
      if (p < 6) begin
        fb = fb_list[p];
        rw = rw_list[p];
      end else begin
        fb = $urandom_range(0, 15);
        rw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 64);
      end
      write_reg_port(REG_FRAC_BITS, {7'($urandom_range(0, 127)), 4'(fb)});
      write_reg_port(REG_ROW_WIDTH, 11'(rw));
      lim = (rw > STORE_DEPTH) ? STORE_DEPTH : rw;
      for (int n = 0; n < 20; n++) begin
        if (n % 10 == 0) steady_feed = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        if (r < 25) begin
          issue_item(mk_load($urandom_range(0, STORE_DEPTH - 1), $urandom));
        end else begin
          if (lim > 0 && $urandom_range(0, 9) < 8) col = $urandom_range(0, lim - 1);
          else col = $urandom_range(0, STORE_DEPTH - 1);
          if ($urandom_range(0, 9) < 8) begin
            // small integer shift keeps the taps near the chosen column
            ip = int'($urandom_range(0, 8)) - 4;
            off = 16'((ip <<< fb) | ($urandom & ((1 << fb) - 1)));
          end else begin
            off = OFFSET_W'($urandom);
          end
          issue_item(mk_comp(col, off));
        end
      end
      steady_feed = 1'b0;
    end

    settle();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending_pixels.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
